>>> src/dpc_pkg.sv
// ============================================================================
// dpc_pkg: shared types and constants of the dryer panel controller
// Event codes, screen and status codes, request and result layouts, and
// small helpers for time arithmetic.
// ============================================================================
package dpc_pkg;

    // Time and target constants
    localparam logic [17:0] SEC_PER_HOUR  = 18'd3600;
    localparam logic [17:0] DEF_REMAIN    = 18'd21600;
    localparam logic [17:0] SEC_MAX       = 18'd172800;
    localparam logic [5:0]  HOURS_MIN     = 6'd6;
    localparam logic [5:0]  HOURS_MAX     = 6'd48;
    localparam logic [5:0]  HOURS_STEP    = 6'd2;
    localparam logic [5:0]  TEMP_HI       = 6'd50;
    localparam logic [5:0]  TEMP_LO       = 6'd40;
    localparam logic [5:0]  TEMP_MID      = 6'd45;
    localparam logic [7:0]  COUNT_MAX     = 8'd255;

    // Configuration reset values and register indexes
    localparam logic [7:0]  IDLE_TO_RST   = 8'd180;
    localparam logic [7:0]  SCR_TO_RST    = 8'd5;
    localparam logic [7:0]  CFG_IDLE_TO   = 8'd0;
    localparam logic [7:0]  CFG_SCR_TO    = 8'd1;

    typedef enum logic [3:0] {
        MODE_TICK   = 4'd0,
        MODE_TOGGLE = 4'd1,
        MODE_ON     = 4'd2,
        MODE_OFF    = 4'd3,
        MODE_PRESSM = 4'd4,
        MODE_PRESSA = 4'd5,
        MODE_RESET  = 4'd6,
        MODE_START  = 4'd7,
        MODE_STOP   = 4'd8,
        MODE_SET    = 4'd9
    } t_mode;

    typedef enum logic [1:0] {
        SCR_INFO = 2'd0,
        SCR_TEMP = 2'd1,
        SCR_TIME = 2'd2
    } t_screen;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_OFF = 2'd1,
        ST_BAD = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] idle_timeout;
        logic [7:0] screen_timeout;
    } t_cfg;

    typedef struct packed {
        logic [3:0] mode;
        logic       button_level;
        logic [7:0] target_temp;
        logic [7:0] target_hours;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic        powered;
        logic        drying_active;
        t_screen     screen;
        logic [5:0]  set_temp;
        logic [5:0]  set_hours;
        logic [17:0] dry_elapsed;
        logic [17:0] dry_left;
        logic        button_edge;
    } t_result;

    // Convert target hours to seconds
    function automatic logic [17:0] hours_to_sec(input logic [5:0] hours);
        return 18'({12'd0, hours} * SEC_PER_HOUR);
    endfunction

    // Saturating 8-bit increment
    function automatic logic [7:0] count_up(input logic [7:0] cnt);
        return (cnt == COUNT_MAX) ? cnt : cnt + 8'd1;
    endfunction

endpackage

>>> src/dpc_cfg_regs.sv
// ============================================================================
// dpc_cfg_regs: configuration registers
// Holds the idle power-off timeout and the screen return timeout.
// ============================================================================
module dpc_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [7:0]        i_index,
    input  logic [7:0]        i_data,
    output dpc_pkg::t_cfg     o_cfg
);

    dpc_pkg::t_cfg r_cfg;

    // Write the addressed register; ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_timeout   <= dpc_pkg::IDLE_TO_RST;
            r_cfg.screen_timeout <= dpc_pkg::SCR_TO_RST;
        end else if (i_wr_en) begin
            unique case (i_index)
                dpc_pkg::CFG_IDLE_TO: r_cfg.idle_timeout   <= i_data;
                dpc_pkg::CFG_SCR_TO:  r_cfg.screen_timeout <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/dpc_core.sv
// ============================================================================
// dpc_core: panel state and event update
// Holds the controller state and computes the effect of one event in a
// single pass; the state advances when the event is committed.
// ============================================================================
module dpc_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  dpc_pkg::t_item      i_item,
    input  dpc_pkg::t_cfg       i_cfg,
    output dpc_pkg::t_result    o_result
);

    logic              r_power,   n_power;
    logic              r_active,  n_active;
    dpc_pkg::t_screen  r_screen,  n_screen;
    logic [5:0]        r_temp,    n_temp;
    logic [5:0]        r_hours,   n_hours;
    logic [17:0]       r_total,   n_total;
    logic [17:0]       r_elapsed, n_elapsed;
    logic [17:0]       r_remain,  n_remain;
    logic [7:0]        r_idle,    n_idle;
    logic [7:0]        r_scr,     n_scr;
    logic              r_button,  n_button;

    dpc_pkg::t_status  w_status;
    logic              w_edge;

    // Compute the next state for the event in the input register
    always_comb begin
        logic        v_do_pwr;
        logic        v_pwr_target;
        logic        v_do_target;
        logic [7:0]  v_t;
        logic [7:0]  v_h;
        logic [17:0] v_elapsed;
        logic [7:0]  v_idle;
        logic [7:0]  v_scr;
        logic [5:0]  v_hours;
        logic        v_bad;

        n_power   = r_power;
        n_active  = r_active;
        n_screen  = r_screen;
        n_temp    = r_temp;
        n_hours   = r_hours;
        n_total   = r_total;
        n_elapsed = r_elapsed;
        n_remain  = r_remain;
        n_idle    = r_idle;
        n_scr     = r_scr;
        n_button  = r_button;
        w_status  = dpc_pkg::ST_OK;
        w_edge    = 1'b0;

        v_do_pwr     = 1'b0;
        v_pwr_target = 1'b0;
        v_do_target  = 1'b0;
        v_t          = 8'd0;
        v_h          = 8'd0;
        v_elapsed    = r_elapsed + 18'd1;
        v_idle       = dpc_pkg::count_up(r_idle);
        v_scr        = dpc_pkg::count_up(r_scr);
        v_hours      = 6'd0;
        v_bad        = 1'b0;

        unique case (dpc_pkg::t_mode'(i_item.mode))
            dpc_pkg::MODE_TICK: begin
                w_edge   = i_item.button_level & ~r_button;
                n_button = i_item.button_level;
                if (!r_power) begin
                    n_idle = 8'd0;
                    n_scr  = 8'd0;
                end else begin
                    // Count drying time or idle time
                    if (r_active) begin
                        n_elapsed = v_elapsed;
                        if (v_elapsed >= r_total) begin
                            n_remain = 18'd0;
                            n_active = 1'b0;
                            n_power  = 1'b0;
                        end else begin
                            n_remain = r_total - v_elapsed;
                        end
                    end else if (v_idle >= i_cfg.idle_timeout) begin
                        n_power = 1'b0;
                        n_idle  = 8'd0;
                    end else begin
                        n_idle = v_idle;
                    end
                    // Return a setting screen to info after its timeout
                    if (r_screen != dpc_pkg::SCR_INFO) begin
                        if (v_scr >= i_cfg.screen_timeout) begin
                            n_screen = dpc_pkg::SCR_INFO;
                            n_scr    = 8'd0;
                        end else begin
                            n_scr = v_scr;
                        end
                    end
                end
            end
            dpc_pkg::MODE_TOGGLE: begin
                v_do_pwr     = 1'b1;
                v_pwr_target = ~r_power;
            end
            dpc_pkg::MODE_ON: begin
                v_do_pwr     = 1'b1;
                v_pwr_target = 1'b1;
            end
            dpc_pkg::MODE_OFF: begin
                v_do_pwr     = 1'b1;
                v_pwr_target = 1'b0;
            end
            dpc_pkg::MODE_PRESSM: begin
                if (!r_power) begin
                    w_status = dpc_pkg::ST_OFF;
                end else begin
                    case (r_screen)
                        dpc_pkg::SCR_INFO: n_screen = dpc_pkg::SCR_TEMP;
                        dpc_pkg::SCR_TEMP: n_screen = dpc_pkg::SCR_TIME;
                        dpc_pkg::SCR_TIME: begin
                            // Leaving the time screen starts drying
                            n_screen  = dpc_pkg::SCR_INFO;
                            n_active  = 1'b1;
                            n_elapsed = 18'd0;
                            n_remain  = r_total;
                        end
                        default: ;
                    endcase
                    n_scr = 8'd0;
                end
            end
            dpc_pkg::MODE_PRESSA: begin
                if (!r_power) begin
                    w_status = dpc_pkg::ST_OFF;
                end else begin
                    if (r_screen == dpc_pkg::SCR_TEMP) begin
                        if (r_temp == dpc_pkg::TEMP_HI) begin
                            n_temp = dpc_pkg::TEMP_LO;
                        end else if (r_temp == dpc_pkg::TEMP_LO) begin
                            n_temp = dpc_pkg::TEMP_MID;
                        end else begin
                            n_temp = dpc_pkg::TEMP_HI;
                        end
                    end else if (r_screen == dpc_pkg::SCR_TIME) begin
                        v_hours  = (r_hours >= dpc_pkg::HOURS_MAX) ? dpc_pkg::HOURS_MIN
                                                                  : r_hours + dpc_pkg::HOURS_STEP;
                        n_hours  = v_hours;
                        n_total  = dpc_pkg::hours_to_sec(v_hours);
                        n_remain = dpc_pkg::hours_to_sec(v_hours);
                    end
                    n_scr = 8'd0;
                end
            end
            dpc_pkg::MODE_RESET: begin
                n_power   = 1'b1;
                n_active  = 1'b0;
                n_screen  = dpc_pkg::SCR_INFO;
                n_temp    = dpc_pkg::TEMP_HI;
                n_hours   = dpc_pkg::HOURS_MIN;
                n_total   = dpc_pkg::DEF_REMAIN;
                n_elapsed = 18'd0;
                n_remain  = dpc_pkg::DEF_REMAIN;
                n_idle    = 8'd0;
                n_scr     = 8'd0;
            end
            dpc_pkg::MODE_START: begin
                v_do_target = 1'b1;
                v_t         = {2'b00, r_temp};
                v_h         = {2'b00, r_hours};
            end
            dpc_pkg::MODE_STOP: begin
                n_active     = 1'b0;
                n_elapsed    = 18'd0;
                v_do_pwr     = 1'b1;
                v_pwr_target = 1'b0;
            end
            dpc_pkg::MODE_SET: begin
                v_do_target = 1'b1;
                v_t         = i_item.target_temp;
                v_h         = i_item.target_hours;
            end
            default: ;
        endcase

        // Apply a power change; a command to the present state does nothing
        if (v_do_pwr && (r_power != v_pwr_target)) begin
            n_power = v_pwr_target;
            if (!v_pwr_target) begin
                n_active  = 1'b0;
                n_screen  = dpc_pkg::SCR_INFO;
                n_elapsed = 18'd0;
            end
            n_idle = 8'd0;
            n_scr  = 8'd0;
        end

        // Validate and apply new targets, then start drying
        if (v_do_target) begin
            v_bad = ((v_t != {2'b00, dpc_pkg::TEMP_LO})  &&
                     (v_t != {2'b00, dpc_pkg::TEMP_MID}) &&
                     (v_t != {2'b00, dpc_pkg::TEMP_HI}))  ||
                    (v_h < {2'b00, dpc_pkg::HOURS_MIN})  ||
                    (v_h > {2'b00, dpc_pkg::HOURS_MAX})  ||
                    v_h[0];
            if (v_bad) begin
                w_status = dpc_pkg::ST_BAD;
            end else begin
                n_power   = 1'b1;
                n_active  = 1'b1;
                n_screen  = dpc_pkg::SCR_INFO;
                n_temp    = v_t[5:0];
                n_hours   = v_h[5:0];
                n_total   = dpc_pkg::hours_to_sec(v_h[5:0]);
                n_elapsed = 18'd0;
                n_remain  = dpc_pkg::hours_to_sec(v_h[5:0]);
                n_idle    = 8'd0;
                n_scr     = 8'd0;
            end
        end
    end

    // Commit the state when the event moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power   <= 1'b0;
            r_active  <= 1'b0;
            r_screen  <= dpc_pkg::SCR_INFO;
            r_temp    <= dpc_pkg::TEMP_MID;
            r_hours   <= dpc_pkg::HOURS_MIN;
            r_total   <= dpc_pkg::DEF_REMAIN;
            r_elapsed <= 18'd0;
            r_remain  <= dpc_pkg::DEF_REMAIN;
            r_idle    <= 8'd0;
            r_scr     <= 8'd0;
            r_button  <= 1'b0;
        end else if (i_step) begin
            r_power   <= n_power;
            r_active  <= n_active;
            r_screen  <= n_screen;
            r_temp    <= n_temp;
            r_hours   <= n_hours;
            r_total   <= n_total;
            r_elapsed <= n_elapsed;
            r_remain  <= n_remain;
            r_idle    <= n_idle;
            r_scr     <= n_scr;
            r_button  <= n_button;
        end
    end

    // Report status and the state after the event
    always_comb begin
        o_result.status        = w_status;
        o_result.powered       = n_power;
        o_result.drying_active = n_active;
        o_result.screen        = n_screen;
        o_result.set_temp      = n_temp;
        o_result.set_hours     = n_hours;
        o_result.dry_elapsed   = n_elapsed;
        o_result.dry_left      = n_remain;
        o_result.button_edge   = w_edge;
    end

endmodule

>>> src/dryer_panel_controller_unit.sv
// ============================================================================
// dryer_panel_controller_unit: front-panel controller of a drying appliance
// Takes one panel event per request and returns one result per event.
// ============================================================================
// Each event request is captured in an input register, runs through the
// state-update logic once and lands in a result register, so one event is
// taken every clock cycle while results drain; its result shows once it
// enters the result register. The dpc_core state-update pass between the
// two registers sets the rate. A result waiting in the result register does
// not block the input side while the input register is free. Configuration
// writes are always accepted and take effect at the next clock edge.
module dryer_panel_controller_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Event requests
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_mode,
    input  logic        i_button_level,
    input  logic [7:0]  i_target_temp,
    input  logic [7:0]  i_target_hours,
    // Results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_powered,
    output logic        o_drying_active,
    output logic [1:0]  o_screen,
    output logic [5:0]  o_set_temp,
    output logic [5:0]  o_set_hours,
    output logic [17:0] o_dry_elapsed,
    output logic [17:0] o_dry_left,
    output logic        o_button_edge,
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic               r_in_valid;
    dpc_pkg::t_item     r_in;
    logic               r_out_valid;
    dpc_pkg::t_result   r_out;
    logic               w_move;
    logic               w_in_take;
    dpc_pkg::t_cfg      w_cfg;
    dpc_pkg::t_result   w_result;

    // Advance an event when the result register is free or being drained
    assign w_move      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_move;
    assign w_in_take   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    dpc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    dpc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_move),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Track occupancy of the input and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_move) begin
                r_in_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture request and result payloads
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.mode         <= i_mode;
            r_in.button_level <= i_button_level;
            r_in.target_temp  <= i_target_temp;
            r_in.target_hours <= i_target_hours;
        end
        if (w_move) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_powered       = r_out.powered;
    assign o_drying_active = r_out.drying_active;
    assign o_screen        = r_out.screen;
    assign o_set_temp      = r_out.set_temp;
    assign o_set_hours     = r_out.set_hours;
    assign o_dry_elapsed   = r_out.dry_elapsed;
    assign o_dry_left      = r_out.dry_left;
    assign o_button_edge   = r_out.button_edge;

    // Drying never runs with power off
    a_active_needs_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drying_active |-> o_powered)
        else $error("drying reported while powered off");

    // A powered-off rejection leaves power off
    a_off_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == dpc_pkg::ST_OFF) |-> !o_powered)
        else $error("powered-off status with power on");

    // Remaining time never exceeds the longest cycle
    a_remain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_dry_left <= dpc_pkg::SEC_MAX))
        else $error("remaining seconds out of range");

endmodule

>>> tb/tb.sv
// ============================================================================
// tb: self-checking bench for the dryer panel controller
// Drives panel event requests and register writes through valid/ready
// channels, predicts every result with a behavioral model of the panel
// state, and compares each returned result field by field.
// ============================================================================
module tb;

    localparam int          CLK_HALF     = 5;
    localparam int          RESET_CYCLES = 5;
    localparam int          RUN_LIMIT    = 2_000_000;
    localparam int          DRY_TICKS    = 200;
    localparam logic [7:0]  CFG_SPARE    = 8'd2;

    typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY} t_rx_style;

    // Clock, reset and block ports
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [3:0]  i_mode;
    logic        i_button_level;
    logic [7:0]  i_target_temp;
    logic [7:0]  i_target_hours;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic        o_powered;
    logic        o_drying_active;
    logic [1:0]  o_screen;
    logic [5:0]  o_set_temp;
    logic [5:0]  o_set_hours;
    logic [17:0] o_dry_elapsed;
    logic [17:0] o_dry_left;
    logic        o_button_edge;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    // Modeled panel state and timeout registers
    logic              pwr_on;
    logic              drying_on;
    dpc_pkg::t_screen  scr_now;
    logic [5:0]        temp_set;
    logic [5:0]        hours_set;
    logic [17:0]       elapsed_s;
    logic [17:0]       remaining_s;
    logic [7:0]        idle_cnt;
    logic [7:0]        scr_cnt;
    logic              btn_prev;
    logic [7:0]        idle_limit;
    logic [7:0]        screen_limit;

    dpc_pkg::t_result  reports_due[$];
    int unsigned fail_count = 0;
    int unsigned burst_left = 0;
    int unsigned hold_left  = 0;

    dryer_panel_controller_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_button_level  (i_button_level),
        .i_target_temp   (i_target_temp),
        .i_target_hours  (i_target_hours),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_powered       (o_powered),
        .o_drying_active (o_drying_active),
        .o_screen        (o_screen),
        .o_set_temp      (o_set_temp),
        .o_set_hours     (o_set_hours),
        .o_dry_elapsed   (o_dry_elapsed),
        .o_dry_left      (o_dry_left),
        .o_button_edge   (o_button_edge),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // Change power; leaving power clears drying, screen and elapsed time
    function automatic void set_power(input logic on);
        if (pwr_on == on)
            return;
        pwr_on = on;
        if (!on) begin
            drying_on = 1'b0;
            scr_now   = dpc_pkg::SCR_INFO;
            elapsed_s = '0;
        end
        idle_cnt = '0;
        scr_cnt  = '0;
    endfunction

    // Validate requested targets and start drying with them
    function automatic dpc_pkg::t_status load_target(input logic [7:0] t,
                                                     input logic [7:0] h);
        if (t != dpc_pkg::TEMP_LO && t != dpc_pkg::TEMP_MID && t != dpc_pkg::TEMP_HI)
            return dpc_pkg::ST_BAD;
        if (h < dpc_pkg::HOURS_MIN || h > dpc_pkg::HOURS_MAX || h[0])
            return dpc_pkg::ST_BAD;
        pwr_on      = 1'b1;
        drying_on   = 1'b1;
        scr_now     = dpc_pkg::SCR_INFO;
        temp_set    = t[5:0];
        hours_set   = h[5:0];
        elapsed_s   = '0;
        remaining_s = 18'(int'(h) * int'(dpc_pkg::SEC_PER_HOUR));
        idle_cnt    = '0;
        scr_cnt     = '0;
        return dpc_pkg::ST_OK;
    endfunction

    // Apply one panel event to the modeled state and return its result
    function automatic dpc_pkg::t_result panel_event_update(input logic [3:0] mode,
                                                            input logic lvl,
                                                            input logic [7:0] req_t,
                                                            input logic [7:0] req_h);
        dpc_pkg::t_result r;
        dpc_pkg::t_status st;
        logic             rise;
        int               total;
        st   = dpc_pkg::ST_OK;
        rise = 1'b0;
        case (mode)
            dpc_pkg::MODE_TICK: begin
                rise     = lvl & ~btn_prev;
                btn_prev = lvl;
                if (!pwr_on) begin
                    idle_cnt = '0;
                    scr_cnt  = '0;
                end else begin
                    if (drying_on) begin
                        total     = int'(hours_set) * int'(dpc_pkg::SEC_PER_HOUR);
                        elapsed_s = elapsed_s + 18'd1;
                        if (int'(elapsed_s) >= total) begin
                            remaining_s = '0;
                            drying_on   = 1'b0;
                            pwr_on      = 1'b0;
                        end else begin
                            remaining_s = 18'(total - int'(elapsed_s));
                        end
                    end else begin
                        if (idle_cnt != dpc_pkg::COUNT_MAX)
                            idle_cnt = idle_cnt + 8'd1;
                        if (idle_cnt >= idle_limit) begin
                            pwr_on   = 1'b0;
                            idle_cnt = '0;
                        end
                    end
                    // Screen return runs even when drying just ended this tick
                    if (scr_now != dpc_pkg::SCR_INFO) begin
                        if (scr_cnt != dpc_pkg::COUNT_MAX)
                            scr_cnt = scr_cnt + 8'd1;
                        if (scr_cnt >= screen_limit) begin
                            scr_now = dpc_pkg::SCR_INFO;
                            scr_cnt = '0;
                        end
                    end
                end
            end
            dpc_pkg::MODE_TOGGLE: set_power(!pwr_on);
            dpc_pkg::MODE_ON:     set_power(1'b1);
            dpc_pkg::MODE_OFF:    set_power(1'b0);
            dpc_pkg::MODE_PRESSM: begin
                if (!pwr_on) begin
                    st = dpc_pkg::ST_OFF;
                end else begin
                    case (scr_now)
                        dpc_pkg::SCR_INFO: scr_now = dpc_pkg::SCR_TEMP;
                        dpc_pkg::SCR_TEMP: scr_now = dpc_pkg::SCR_TIME;
                        dpc_pkg::SCR_TIME: begin
                            scr_now     = dpc_pkg::SCR_INFO;
                            drying_on   = 1'b1;
                            elapsed_s   = '0;
                            remaining_s = 18'(int'(hours_set) * int'(dpc_pkg::SEC_PER_HOUR));
                        end
                        default: ;
                    endcase
                    scr_cnt = '0;
                end
            end
            dpc_pkg::MODE_PRESSA: begin
                if (!pwr_on) begin
                    st = dpc_pkg::ST_OFF;
                end else begin
                    if (scr_now == dpc_pkg::SCR_TEMP) begin
                        if (temp_set == dpc_pkg::TEMP_HI)
                            temp_set = dpc_pkg::TEMP_LO;
                        else if (temp_set == dpc_pkg::TEMP_LO)
                            temp_set = dpc_pkg::TEMP_MID;
                        else
                            temp_set = dpc_pkg::TEMP_HI;
                    end else if (scr_now == dpc_pkg::SCR_TIME) begin
                        if (hours_set >= dpc_pkg::HOURS_MAX)
                            hours_set = dpc_pkg::HOURS_MIN;
                        else
                            hours_set = hours_set + dpc_pkg::HOURS_STEP;
                        remaining_s = 18'(int'(hours_set) * int'(dpc_pkg::SEC_PER_HOUR));
                    end
                    scr_cnt = '0;
                end
            end
            dpc_pkg::MODE_RESET: begin
                pwr_on      = 1'b1;
                drying_on   = 1'b0;
                scr_now     = dpc_pkg::SCR_INFO;
                temp_set    = dpc_pkg::TEMP_HI;
                hours_set   = dpc_pkg::HOURS_MIN;
                elapsed_s   = '0;
                remaining_s = dpc_pkg::DEF_REMAIN;
                idle_cnt    = '0;
                scr_cnt     = '0;
            end
            dpc_pkg::MODE_START: st = load_target(8'(temp_set), 8'(hours_set));
            dpc_pkg::MODE_STOP: begin
                drying_on = 1'b0;
                elapsed_s = '0;
                set_power(1'b0);
            end
            dpc_pkg::MODE_SET: st = load_target(req_t, req_h);
            default: ;
        endcase
        r.status        = st;
        r.powered       = pwr_on;
        r.drying_active = drying_on;
        r.screen        = scr_now;
        r.set_temp      = temp_set;
        r.set_hours     = hours_set;
        r.dry_elapsed   = elapsed_s;
        r.dry_left      = remaining_s;
        r.button_edge   = rise;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [17:0] want,
                                        input logic [17:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each accepted result with the oldest pending one
    always @(posedge i_clk) begin
        dpc_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (reports_due.size() == 0) begin
                $error("result returned with no event request pending");
                fail_count++;
            end else begin
                want = reports_due.pop_front();
                check_field("status", 18'(want.status), 18'(o_status));
                check_field("powered", 18'(want.powered), 18'(o_powered));
                check_field("drying_active", 18'(want.drying_active), 18'(o_drying_active));
                check_field("screen", 18'(want.screen), 18'(o_screen));
                check_field("set_temp", 18'(want.set_temp), 18'(o_set_temp));
                check_field("set_hours", 18'(want.set_hours), 18'(o_set_hours));
                check_field("dry_elapsed", want.dry_elapsed, o_dry_elapsed);
                check_field("dry_left", want.dry_left, o_dry_left);
                check_field("button_edge", 18'(want.button_edge), 18'(o_button_edge));
            end
        end
    end

    // Result side: stall in styles that change over time, or hold off on demand
    initial begin : result_side
        t_rx_style   style;
        int unsigned style_left;
        i_out_ready = 1'b0;
        style       = RX_FREE;
        style_left  = 0;
        forever begin
            @(negedge i_clk);
            if (style_left == 0) begin
                style      = t_rx_style'($urandom_range(0, 2));
                style_left = $urandom_range(20, 200);
            end
            style_left--;
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (style)
                    RX_FREE:  i_out_ready <= 1'b1;
                    RX_LIGHT: i_out_ready <= ($urandom_range(0, 3) != 0);
                    default:  i_out_ready <= ($urandom_range(0, 2) == 0);
                endcase
            end
        end
    end

    // Send one event request in bursts with random gaps, and log its result
    task automatic send_event(input logic [3:0] mode, input logic lvl,
                              input logic [7:0] req_t, input logic [7:0] req_h);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 2);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_button_level <= lvl;
        i_target_temp  <= req_t;
        i_target_hours <= req_h;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        reports_due.push_back(panel_event_update(mode, lvl, req_t, req_h));
    endtask

    // Drop the request and let every pending result come back
    task automatic wait_all_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one timeout register while the block is idle
    task automatic write_register(input logic [7:0] idx, input logic [7:0] data);
        wait_all_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx == dpc_pkg::CFG_IDLE_TO)
            idle_limit = data;
        else if (idx == dpc_pkg::CFG_SCR_TO)
            screen_limit = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Pick an event, mostly ticks, presses and well-formed targets
    task automatic pick_event(output logic [3:0] mode, output logic lvl,
                              output logic [7:0] req_t, output logic [7:0] req_h);
        int unsigned roll;
        roll  = $urandom_range(0, 99);
        lvl   = 1'($urandom_range(0, 1));
        req_t = 8'($urandom_range(0, 255));
        req_h = 8'($urandom_range(0, 255));
        if (roll < 45)
            mode = dpc_pkg::MODE_TICK;
        else if (roll < 54)
            mode = dpc_pkg::MODE_PRESSM;
        else if (roll < 63)
            mode = dpc_pkg::MODE_PRESSA;
        else if (roll < 67)
            mode = dpc_pkg::MODE_TOGGLE;
        else if (roll < 70)
            mode = dpc_pkg::MODE_ON;
        else if (roll < 72)
            mode = dpc_pkg::MODE_OFF;
        else if (roll < 75)
            mode = dpc_pkg::MODE_RESET;
        else if (roll < 79)
            mode = dpc_pkg::MODE_START;
        else if (roll < 82)
            mode = dpc_pkg::MODE_STOP;
        else if (roll < 96) begin
            mode = dpc_pkg::MODE_SET;
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 2))
                    0:       req_t = 8'(dpc_pkg::TEMP_LO);
                    1:       req_t = 8'(dpc_pkg::TEMP_MID);
                    default: req_t = 8'(dpc_pkg::TEMP_HI);
                endcase
                req_h = 8'(2 * $urandom_range(int'(dpc_pkg::HOURS_MIN) / 2,
                                              int'(dpc_pkg::HOURS_MAX) / 2));
            end
        end else
            mode = 4'($urandom_range(int'(dpc_pkg::MODE_SET) + 1, 15));
    endtask

    // Every event type, presses while off, screen and target cycling, bad targets
    task automatic test_panel_basics();
        send_event(dpc_pkg::MODE_TICK, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_PRESSM, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_PRESSA, 1'b1, 8'd255, 8'd255);
        send_event(4'd15, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_OFF, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_ON, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_ON, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_TICK, 1'b1, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_TICK, 1'b1, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_PRESSA, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_PRESSM, 1'b0, 8'd0, 8'd0);
        repeat (3) send_event(dpc_pkg::MODE_PRESSA, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_PRESSM, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_PRESSA, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_PRESSM, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_TICK, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_SET, 1'b0, 8'd255, 8'd48);
        send_event(dpc_pkg::MODE_SET, 1'b0, 8'd50, 8'd7);
        send_event(dpc_pkg::MODE_SET, 1'b0, 8'd45, 8'd50);
        send_event(dpc_pkg::MODE_SET, 1'b0, 8'd40, 8'd4);
        send_event(dpc_pkg::MODE_SET, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_SET, 1'b0, 8'd40, 8'd48);
        send_event(dpc_pkg::MODE_SET, 1'b0, 8'd50, 8'd6);
        send_event(dpc_pkg::MODE_STOP, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_RESET, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_START, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_TOGGLE, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_TOGGLE, 1'b0, 8'd0, 8'd0);
    endtask

    // Shortest, zero and longest timeouts, and a write to an unused index
    task automatic test_timeout_registers();
        write_register(dpc_pkg::CFG_IDLE_TO, 8'd1);
        write_register(dpc_pkg::CFG_SCR_TO, 8'd1);
        send_event(dpc_pkg::MODE_ON, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_PRESSM, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_TICK, 1'b1, 8'd0, 8'd0);
        write_register(dpc_pkg::CFG_IDLE_TO, 8'd0);
        write_register(dpc_pkg::CFG_SCR_TO, 8'd0);
        send_event(dpc_pkg::MODE_ON, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_PRESSM, 1'b0, 8'd0, 8'd0);
        repeat (2) send_event(dpc_pkg::MODE_TICK, 1'b0, 8'd0, 8'd0);
        write_register(dpc_pkg::CFG_IDLE_TO, 8'd255);
        write_register(dpc_pkg::CFG_SCR_TO, 8'd255);
        send_event(dpc_pkg::MODE_ON, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_PRESSM, 1'b0, 8'd0, 8'd0);
        repeat (256) send_event(dpc_pkg::MODE_TICK, 1'($urandom_range(0, 1)), 8'd0, 8'd0);
        write_register(CFG_SPARE, 8'd3);
        send_event(dpc_pkg::MODE_ON, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_PRESSM, 1'b0, 8'd0, 8'd0);
        repeat (6) send_event(dpc_pkg::MODE_TICK, 1'b0, 8'd0, 8'd0);
    endtask

    // Step hours all the way around on the time screen, then start from M
    task automatic test_hours_cycle();
        send_event(dpc_pkg::MODE_RESET, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_PRESSM, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_PRESSA, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_PRESSM, 1'b0, 8'd0, 8'd0);
        repeat (23) send_event(dpc_pkg::MODE_PRESSA, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_PRESSM, 1'b0, 8'd0, 8'd0);
        send_event(dpc_pkg::MODE_STOP, 1'b0, 8'd0, 8'd0);
    endtask

    // Run a stretch of drying so elapsed and remaining time advance, then stop
    task automatic test_drying_run();
        write_register(dpc_pkg::CFG_IDLE_TO, dpc_pkg::IDLE_TO_RST);
        write_register(dpc_pkg::CFG_SCR_TO, dpc_pkg::SCR_TO_RST);
        send_event(dpc_pkg::MODE_SET, 1'b0, 8'(dpc_pkg::TEMP_HI), 8'(dpc_pkg::HOURS_MIN));
        for (int i = 0; i < DRY_TICKS; i++) begin
            // Leave the info screen now and then; the screen timer brings it back
            if (i % 50 == 25 && scr_now == dpc_pkg::SCR_INFO)
                send_event(dpc_pkg::MODE_PRESSM, 1'b0, 8'd0, 8'd0);
            send_event(dpc_pkg::MODE_TICK, 1'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        send_event(dpc_pkg::MODE_STOP, 1'b0, 8'd0, 8'd0);
    endtask

    // Hold results back long enough that the block stalls its input
    task automatic test_input_backpressure();
        logic [3:0] m;
        logic       lvl;
        logic [7:0] t;
        logic [7:0] h;
        send_event(dpc_pkg::MODE_ON, 1'b0, 8'd0, 8'd0);
        hold_left = 300;
        repeat (40) begin
            pick_event(m, lvl, t, h);
            send_event(m, lvl, t, h);
        end
    endtask

    // Random traffic under one timeout setting, with runs of ticks
    task automatic test_random_traffic(input int unsigned items, input logic [7:0] idle_to,
                                       input logic [7:0] scr_to);
        int unsigned sent;
        int unsigned run_len;
        logic [3:0]  m;
        logic        lvl;
        logic [7:0]  t;
        logic [7:0]  h;
        write_register(dpc_pkg::CFG_IDLE_TO, idle_to);
        write_register(dpc_pkg::CFG_SCR_TO, scr_to);
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(0, 29) == 0) begin
                run_len = $urandom_range(1, int'(idle_limit) + 8);
                repeat (run_len)
                    send_event(dpc_pkg::MODE_TICK, 1'($urandom_range(0, 1)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                sent += run_len;
            end else begin
                pick_event(m, lvl, t, h);
                send_event(m, lvl, t, h);
                sent++;
            end
        end
    endtask

    initial begin
        #(RUN_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_mode         = '0;
        i_button_level = 1'b0;
        i_target_temp  = '0;
        i_target_hours = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        pwr_on         = 1'b0;
        drying_on      = 1'b0;
        scr_now        = dpc_pkg::SCR_INFO;
        temp_set       = dpc_pkg::TEMP_MID;
        hours_set      = dpc_pkg::HOURS_MIN;
        elapsed_s      = '0;
        remaining_s    = dpc_pkg::DEF_REMAIN;
        idle_cnt       = '0;
        scr_cnt        = '0;
        btn_prev       = 1'b0;
        idle_limit     = dpc_pkg::IDLE_TO_RST;
        screen_limit   = dpc_pkg::SCR_TO_RST;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_panel_basics();
        test_timeout_registers();
        test_hours_cycle();
        test_drying_run();
        test_input_backpressure();
        test_random_traffic(300, dpc_pkg::IDLE_TO_RST, dpc_pkg::SCR_TO_RST);
        test_random_traffic(250, 8'($urandom_range(2, 20)), 8'($urandom_range(1, 8)));
        test_random_traffic(200, 8'd255, 8'd255);
        test_random_traffic(150, 8'd1, 8'd1);
        test_random_traffic(170, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));

        wait_all_results();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
src/dpc_pkg.sv
src/dpc_cfg_regs.sv
src/dpc_core.sv
src/dryer_panel_controller_unit.sv
tb/tb.sv
